/* hw/rtl/vsmu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsmu_pkg
// Shared types and constants for the vector/scalar move unit.
// ----------------------------------------------------------------------------
package vsmu_pkg;

	// operation codes
	localparam logic [2:0] FUNC_VMV_X_S  = 3'd0;
	localparam logic [2:0] FUNC_VMV_S_X  = 3'd1;
	localparam logic [2:0] FUNC_VFMV_F_S = 3'd2;
	localparam logic [2:0] FUNC_VFMV_S_F = 3'd3;
	localparam logic [2:0] FUNC_VMV_NR   = 3'd4;

	// element width codes
	localparam logic [2:0] EW_8  = 3'd0;
	localparam logic [2:0] EW_16 = 3'd1;
	localparam logic [2:0] EW_32 = 3'd2;
	localparam logic [2:0] EW_64 = 3'd3;

	localparam logic [63:0] KEEP_8      = 64'hFFFF_FFFF_FFFF_FF00;
	localparam logic [63:0] KEEP_16     = 64'hFFFF_FFFF_FFFF_0000;
	localparam logic [63:0] HI32_ONES   = 64'hFFFF_FFFF_0000_0000;
	localparam logic [63:0] ONES64      = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] LO32_ONES   = 32'hFFFF_FFFF;
	localparam logic [31:0] CANON_NAN32 = 32'h7FC0_0000;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] scalar_in;
		logic [63:0] vsrc_lo;
		logic [63:0] vsrc_hi;
		logic [63:0] old_lo;
		logic [63:0] old_hi;
		logic [6:0]  start_index;
		logic [7:0]  vector_length;
		logic [2:0]  elem_width;
		logic        tail_agnostic;
	} move_req_t;

	typedef struct packed {
		logic [63:0] result_lo;
		logic [63:0] result_hi;
	} move_res_t;

endpackage

/* hw/rtl/vsmu_move_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsmu_move_core
// Combinational datapath: selects and fills the result of one move.
// ----------------------------------------------------------------------------
module vsmu_move_core (
	input  vsmu_pkg::move_req_t req,
	output vsmu_pkg::move_res_t res
);
	import vsmu_pkg::*;

	logic        empty;
	logic [63:0] sext_lo;
	logic [63:0] tail_hi;
	logic [63:0] sx_lo;
	logic [63:0] fsx_lo;
	logic [31:0] fsx_e0;
	logic [63:0] whole_lo;
	logic [63:0] whole_hi;
	logic [127:0] whole_src;
	logic [127:0] whole_old;
	logic [127:0] whole_res;

	// no active element: vl is zero or vstart reaches vl
	assign empty = (req.vector_length == 8'd0) ||
		({1'b0, req.start_index} >= req.vector_length);

	assign tail_hi = req.tail_agnostic ? ONES64 : req.old_hi;

	always_comb begin
		case (req.elem_width)
			EW_8:    sext_lo = {{56{req.vsrc_lo[7]}}, req.vsrc_lo[7:0]};
			EW_16:   sext_lo = {{48{req.vsrc_lo[15]}}, req.vsrc_lo[15:0]};
			EW_32:   sext_lo = {{32{req.vsrc_lo[31]}}, req.vsrc_lo[31:0]};
			EW_64:   sext_lo = req.vsrc_lo;
			default: sext_lo = '0;
		endcase
	end

	always_comb begin
		case (req.elem_width)
			EW_8:    sx_lo = ((req.tail_agnostic ? KEEP_8 : (req.old_lo & KEEP_8)) |
				(req.scalar_in & ~KEEP_8));
			EW_16:   sx_lo = ((req.tail_agnostic ? KEEP_16 : (req.old_lo & KEEP_16)) |
				(req.scalar_in & ~KEEP_16));
			EW_32:   sx_lo = ((req.tail_agnostic ? HI32_ONES : (req.old_lo & HI32_ONES)) |
				(req.scalar_in & ~HI32_ONES));
			default: sx_lo = req.scalar_in;
		endcase
	end

	// replace a badly boxed single with the canonical NaN
	assign fsx_e0 = (req.scalar_in[63:32] == LO32_ONES) ? req.scalar_in[31:0] : CANON_NAN32;
	assign fsx_lo = {(req.tail_agnostic ? LO32_ONES : req.old_lo[63:32]), fsx_e0};

	assign whole_src = {req.vsrc_hi, req.vsrc_lo};
	assign whole_old = {req.old_hi, req.old_lo};

	// per byte: copy from source when its element index is at or above vstart
	always_comb begin
		for (int b = 0; b < 16; b++) begin
			logic [3:0] idx;
			idx = 4'(b) >> req.elem_width[1:0];
			whole_res[b*8 +: 8] = ({3'd0, idx} >= req.start_index) ?
				whole_src[b*8 +: 8] : whole_old[b*8 +: 8];
		end
	end
	assign whole_lo = whole_res[63:0];
	assign whole_hi = whole_res[127:64];

	always_comb begin
		res.result_lo = '0;
		res.result_hi = '0;
		case (req.func)
			FUNC_VMV_X_S: begin
				res.result_lo = sext_lo;
			end
			FUNC_VMV_S_X: begin
				if (empty) begin
					res.result_lo = req.old_lo;
					res.result_hi = req.old_hi;
				end else if (!req.elem_width[2]) begin
					res.result_lo = sx_lo;
					res.result_hi = tail_hi;
				end
			end
			FUNC_VFMV_F_S: begin
				if (req.elem_width == EW_32) begin
					res.result_lo = HI32_ONES | {32'd0, req.vsrc_lo[31:0]};
				end else if (req.elem_width == EW_64) begin
					res.result_lo = req.vsrc_lo;
				end
			end
			FUNC_VFMV_S_F: begin
				if (empty) begin
					res.result_lo = req.old_lo;
					res.result_hi = req.old_hi;
				end else if (req.elem_width == EW_32) begin
					res.result_lo = fsx_lo;
					res.result_hi = tail_hi;
				end else if (req.elem_width == EW_64) begin
					res.result_lo = req.scalar_in;
					res.result_hi = tail_hi;
				end
			end
			FUNC_VMV_NR: begin
				if (!req.elem_width[2]) begin
					res.result_lo = whole_lo;
					res.result_hi = whole_hi;
				end
			end
			default: begin
				res.result_lo = '0;
				res.result_hi = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/vector_scalar_move_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_scalar_move_unit
// 128-bit vector/scalar and whole-register move unit, one move per item.
// ----------------------------------------------------------------------------
//  channel | signals                       | direction
//  --------+-------------------------------+----------
//  in      | in_valid, in_ready, fields    | consumer
//  out     | out_valid, out_ready, results | producer
//
// One item per cycle sustained while the output is not stalled; each item
// passes the input register, then the result register, with the move datapath between them.
// arst_n clears both valid flags; payload registers are not reset.
// An output stall holds the result register and backs up into the input
// register; in_ready drops only when both stages are full and out is stalled.
module vector_scalar_move_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [63:0] scalar_in,
	input  logic [63:0] vsrc_lo,
	input  logic [63:0] vsrc_hi,
	input  logic [63:0] old_lo,
	input  logic [63:0] old_hi,
	input  logic [6:0]  start_index,
	input  logic [7:0]  vector_length,
	input  logic [2:0]  elem_width,
	input  logic        tail_agnostic,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_lo,
	output logic [63:0] result_hi
);
	import vsmu_pkg::*;

	move_req_t req_s1;
	logic      valid_s1;
	move_res_t res_s1;
	move_res_t res_q;
	logic      out_valid_q;
	logic      out_free;
	logic      adv_s1;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= '{func: func, scalar_in: scalar_in, vsrc_lo: vsrc_lo,
				vsrc_hi: vsrc_hi, old_lo: old_lo, old_hi: old_hi,
				start_index: start_index, vector_length: vector_length,
				elem_width: elem_width, tail_agnostic: tail_agnostic};
		end
	end

	vsmu_move_core u_core (
		.req (req_s1),
		.res (res_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign result_lo = res_q.result_lo;
	assign result_hi = res_q.result_hi;

`ifndef NO_ASSERTIONS
	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but in_ready low");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted transfer lost from input stage");

	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("input stage did not advance into free result register");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !valid_s1) |=> !out_valid_q)
		else $error("result repeated after transfer");
`endif

endmodule

/* bench/move_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_checker
// Watches both channels of the vector/scalar move unit, computes the result
// of every accepted request, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module move_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  vsmu_pkg::move_req_t req,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [63:0]         result_lo,
	input  logic [63:0]         result_hi,
	output int                  fail_count,
	output int                  pending
);
	import vsmu_pkg::*;

	move_res_t expected_q[$];
	move_res_t want;
	int        errors;

	initial begin
		errors     = 0;
		fail_count = 0;
		pending    = 0;
	end

	function automatic move_res_t predict_move(input move_req_t r);
		move_res_t    res;
		logic         empty;
		logic [63:0]  keep;
		logic [31:0]  elem0;
		logic [127:0] src;
		logic [127:0] old;
		int unsigned  idx;

		res   = '0;
		empty = (r.vector_length == 8'd0) || ({1'b0, r.start_index} >= r.vector_length);
		src   = {r.vsrc_hi, r.vsrc_lo};
		old   = {r.old_hi, r.old_lo};
		case (r.func)
			FUNC_VMV_X_S: begin
				case (r.elem_width)
					EW_8:  res.result_lo = {{56{r.vsrc_lo[7]}}, r.vsrc_lo[7:0]};
					EW_16: res.result_lo = {{48{r.vsrc_lo[15]}}, r.vsrc_lo[15:0]};
					EW_32: res.result_lo = {{32{r.vsrc_lo[31]}}, r.vsrc_lo[31:0]};
					EW_64: res.result_lo = r.vsrc_lo;
					default: ;
				endcase
			end
			FUNC_VMV_S_X: begin
				if (empty) begin
					res = {r.old_lo, r.old_hi};
				end else begin
					case (r.elem_width)
						EW_8, EW_16, EW_32: begin
							keep = ONES64 << (8 << r.elem_width);
							res.result_lo = (r.tail_agnostic ? keep : (r.old_lo & keep))
								| (r.scalar_in & ~keep);
							res.result_hi = r.tail_agnostic ? ONES64 : r.old_hi;
						end
						EW_64: begin
							res.result_lo = r.scalar_in;
							res.result_hi = r.tail_agnostic ? ONES64 : r.old_hi;
						end
						default: ;
					endcase
				end
			end
			FUNC_VFMV_F_S: begin
				case (r.elem_width)
					EW_32:   res.result_lo = {LO32_ONES, r.vsrc_lo[31:0]};
					EW_64:   res.result_lo = r.vsrc_lo;
					default: ;
				endcase
			end
			FUNC_VFMV_S_F: begin
				if (empty) begin
					res = {r.old_lo, r.old_hi};
				end else begin
					case (r.elem_width)
						EW_32: begin
							// replace an improperly boxed single with the canonical NaN
							elem0 = (r.scalar_in[63:32] == LO32_ONES) ? r.scalar_in[31:0]
								: CANON_NAN32;
							res.result_lo = {r.tail_agnostic ? LO32_ONES : r.old_lo[63:32],
								elem0};
							res.result_hi = r.tail_agnostic ? ONES64 : r.old_hi;
						end
						EW_64: begin
							res.result_lo = r.scalar_in;
							res.result_hi = r.tail_agnostic ? ONES64 : r.old_hi;
						end
						default: ;
					endcase
				end
			end
			FUNC_VMV_NR: begin
				if (r.elem_width <= EW_64) begin
					// take each byte from the source when its element is at or past vstart
					for (int b = 0; b < 16; b++) begin
						idx = b >> r.elem_width;
						if (idx >= r.start_index)
							old[b*8 +: 8] = src[b*8 +: 8];
					end
					res = {old[63:0], old[127:64]};
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic void flag(input string msg);
		if (errors < 10)
			$display("%0t: %s", $time, msg);
		errors++;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					flag($sformatf("result %h_%h with nothing expected", result_hi, result_lo));
				end else begin
					want = expected_q.pop_front();
					if (result_lo !== want.result_lo)
						flag($sformatf("result_lo mismatch: expected %h, got %h",
							want.result_lo, result_lo));
					if (result_hi !== want.result_hi)
						flag($sformatf("result_hi mismatch: expected %h, got %h",
							want.result_hi, result_hi));
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict_move(req));
		end
		fail_count <= errors;
		pending    <= expected_q.size();
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the vector/scalar move unit with directed corner cases and random
// moves under random source gaps and sink stalls; the checker does the rest.
// ----------------------------------------------------------------------------
module tb;
	import vsmu_pkg::*;

	localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
	localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
	localparam logic [2:0] EW_UNUSED_LO   = 3'd4;
	localparam logic [2:0] EW_UNUSED_HI   = 3'd7;
	localparam int         RANDOM_ITEMS   = 1400;
	localparam int         IDLE_LIMIT     = 1000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	move_req_t   req;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_lo;
	logic [63:0] result_hi;
	int          fail_count;
	int          pending;

	int unsigned ready_left;
	int unsigned ready_pick;
	int          idle_cycles;

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		out_ready  = 1'b0;
		req        = '0;
		ready_left = 0;
		idle_cycles = 0;
	end

	always #5 clk = ~clk;

	vector_scalar_move_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (req.func),
		.scalar_in    (req.scalar_in),
		.vsrc_lo      (req.vsrc_lo),
		.vsrc_hi      (req.vsrc_hi),
		.old_lo       (req.old_lo),
		.old_hi       (req.old_hi),
		.start_index  (req.start_index),
		.vector_length(req.vector_length),
		.elem_width   (req.elem_width),
		.tail_agnostic(req.tail_agnostic),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_lo    (result_lo),
		.result_hi    (result_hi)
	);

	move_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req       (req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_lo (result_lo),
		.result_hi (result_hi),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// sink: mostly short ready/stall stretches, a few long stalls and calm runs
	always @(posedge clk) begin
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 5) begin
				out_ready  <= 1'b1;
				ready_left <= $urandom_range(100, 300);
			end else if (ready_pick < 65) begin
				out_ready  <= 1'b1;
				ready_left <= $urandom_range(0, 7);
			end else if (ready_pick < 93) begin
				out_ready  <= 1'b0;
				ready_left <= $urandom_range(0, 2);
			end else begin
				out_ready  <= 1'b0;
				ready_left <= $urandom_range(10, 50);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** vector_scalar_move_unit: FAILED **");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic int unsigned pick_gap(input logic quiet);
		int unsigned p;

		p = $urandom_range(0, 99);
		if (quiet || p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic move_req_t make_req(input logic [2:0] f, input logic [2:0] ew,
		input logic [6:0] vs, input logic [7:0] vl, input logic ta, input logic [63:0] sc,
		input logic [63:0] s_lo, input logic [63:0] s_hi,
		input logic [63:0] o_lo, input logic [63:0] o_hi);
		move_req_t r;

		r.func          = f;
		r.elem_width    = ew;
		r.start_index   = vs;
		r.vector_length = vl;
		r.tail_agnostic = ta;
		r.scalar_in     = sc;
		r.vsrc_lo       = s_lo;
		r.vsrc_hi       = s_hi;
		r.old_lo        = o_lo;
		r.old_hi        = o_hi;
		return r;
	endfunction

	function automatic move_req_t rand_req();
		move_req_t   r;
		int unsigned p;

		r = make_req(FUNC_VMV_X_S, EW_8, 7'd0, 8'd0, 1'($urandom_range(0, 1)),
			rand64(), rand64(), rand64(), rand64(), rand64());
		if ($urandom_range(0, 99) < 92)
			r.func = 3'($urandom_range(FUNC_VMV_X_S, FUNC_VMV_NR));
		else
			r.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
		if ($urandom_range(0, 99) < 85)
			r.elem_width = 3'($urandom_range(EW_8, EW_64));
		else
			r.elem_width = 3'($urandom_range(EW_UNUSED_LO, EW_UNUSED_HI));

		p = $urandom_range(0, 9);
		if (p < 5)
			r.start_index = 7'($urandom_range(0, 20));
		else if (p < 8)
			r.start_index = 7'($urandom_range(0, 127));

		p = $urandom_range(0, 19);
		if (p < 8)
			r.vector_length = 8'($urandom_range(1, 32));
		else if (p < 14)
			r.vector_length = 8'($urandom_range(0, 255));
		else if (p < 16)
			r.vector_length = 8'd0;
		else
			r.vector_length = {1'b0, r.start_index} + 8'($urandom_range(0, 1));

		// keep most single-precision moves properly boxed, some off by one bit
		p = $urandom_range(0, 9);
		if (r.func == FUNC_VFMV_S_F && p < 6)
			r.scalar_in[63:32] = LO32_ONES;
		else if (r.func == FUNC_VFMV_S_F && p == 6)
			r.scalar_in[63:32] = LO32_ONES ^ (32'd1 << $urandom_range(0, 31));
		return r;
	endfunction

	task automatic send_req(input move_req_t r, input int unsigned gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req      <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	initial begin
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		a = 64'h0123_4567_89AB_CDEF;
		b = 64'hFEDC_BA98_7654_3210;
		c = 64'hA5A5_5A5A_C3C3_3C3C;
		d = 64'h0F0F_F0F0_1234_8765;

		// integer element 0 to scalar: sign and width extremes
		send_req(make_req(FUNC_VMV_X_S, EW_8, 7'd0, 8'd1, 1'b0, a,
			64'h0000_0000_0000_0080, b, c, d), pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_X_S, EW_16, 7'd127, 8'd0, 1'b1, a,
			64'hFFFF_FFFF_FFFF_7FFF, b, c, d), pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_X_S, EW_32, 7'd3, 8'd9, 1'b0, a,
			64'hFFFF_FFFF_FFFF_FFFF, b, c, d), pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_X_S, EW_UNUSED_HI, 7'd0, 8'd1, 1'b0, a, b, c, d, a),
			pick_gap(1'b0));

		// scalar to element 0, both tail policies, empty length
		send_req(make_req(FUNC_VMV_S_X, EW_8, 7'd0, 8'd1, 1'b1, b, a, c, d, c),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_S_X, EW_16, 7'd0, 8'd16, 1'b0, b, a, c, d, c),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_S_X, EW_32, 7'd1, 8'd2, 1'b1,
			64'hFFFF_FFFF_FFFF_FFFF, a, c, 64'd0, 64'd0), pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_S_X, EW_64, 7'd127, 8'd255, 1'b0, d, a, b,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF), pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_S_X, EW_64, 7'd0, 8'd0, 1'b1, d, a, b, c, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_S_X, EW_8, 7'd5, 8'd5, 1'b1, d, a, b, c, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_S_X, EW_UNUSED_LO, 7'd0, 8'd4, 1'b1, d, a, b, c, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_S_X, EW_UNUSED_HI, 7'd9, 8'd3, 1'b0, d, a, b, c, a),
			pick_gap(1'b0));

		// float element 0 to scalar
		send_req(make_req(FUNC_VFMV_F_S, EW_32, 7'd0, 8'd1, 1'b0, a, b, c, d, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VFMV_F_S, EW_64, 7'd0, 8'd1, 1'b0, a, b, c, d, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VFMV_F_S, EW_8, 7'd0, 8'd1, 1'b0, a, b, c, d, a),
			pick_gap(1'b0));

		// float scalar to element 0: boxed, badly boxed, narrow widths
		send_req(make_req(FUNC_VFMV_S_F, EW_32, 7'd0, 8'd4, 1'b0,
			64'hFFFF_FFFF_3F80_0000, a, b, c, d), pick_gap(1'b0));
		send_req(make_req(FUNC_VFMV_S_F, EW_32, 7'd0, 8'd4, 1'b1,
			64'h7FFF_FFFF_3F80_0000, a, b, c, d), pick_gap(1'b0));
		send_req(make_req(FUNC_VFMV_S_F, EW_64, 7'd2, 8'd3, 1'b1, b, a, b, c, d),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VFMV_S_F, EW_16, 7'd0, 8'd8, 1'b1, b, a, b, c, d),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VFMV_S_F, EW_8, 7'd0, 8'd0, 1'b1, b, a, b, c, d),
			pick_gap(1'b0));

		// whole register move across vstart positions
		send_req(make_req(FUNC_VMV_NR, EW_8, 7'd7, 8'd0, 1'b1, a, b, c, d, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_NR, EW_16, 7'd127, 8'd200, 1'b0, a, b, c, d, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_NR, EW_64, 7'd1, 8'd1, 1'b0, a, b, c, d, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_VMV_NR, EW_UNUSED_LO, 7'd0, 8'd1, 1'b0, a, b, c, d, a),
			pick_gap(1'b0));

		// unused function codes
		send_req(make_req(FUNC_UNUSED_LO, EW_32, 7'd0, 8'd1, 1'b1, a, b, c, d, a),
			pick_gap(1'b0));
		send_req(make_req(FUNC_UNUSED_HI, EW_64, 7'd0, 8'd1, 1'b1, a, b, c, d, a),
			pick_gap(1'b0));

		// random part, with every third block of 200 sent back to back
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_req(rand_req(), pick_gap(((i / 200) % 3) == 1));
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("** vector_scalar_move_unit: PASSED **");
		else
			$display("** vector_scalar_move_unit: FAILED **");
		$finish;
	end

endmodule
